// ===== sv/gno_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gno_pkg
// shared constants for the multi-octave gradient noise pipeline
// ----------------------------------------------------------------------------
package gno_pkg;

  // corner hash multipliers
  localparam logic [31:0] HASH_K1 = 32'd3284157443;
  localparam logic [31:0] HASH_K2 = 32'd1911520717;
  localparam logic [31:0] HASH_K3 = 32'd2048419325;

  // 0.7 in q15, the clamp bound and the rescale divisor
  localparam int CLAMP_Q15 = 22938;
  localparam int MAG_W     = 15;

  // reciprocal of the clamp bound, error stays below one quotient step
  localparam int          RECIP_SHIFT = 17;
  localparam int          RECIP_W     = 18;
  localparam logic [RECIP_W-1:0] RECIP_CLAMP = RECIP_W'((64'd1 << 32) / 64'd22938);

  localparam int GRAD_W    = 17;  // gradient component, q1.15
  localparam int NOISE_W   = 20;  // corner dot and blend values, q15
  localparam int CONTRIB_W = 17;  // one octave's share, q1.15
  localparam int SUM_W     = 18;
  localparam int OUT_W     = 17;
  localparam int CFG_W     = 4;

  localparam int LANE_LAT   = 13;            // register stages in one octave lane
  localparam int PIPE_DEPTH = LANE_LAT + 3;  // accept edge to strobe sample edge

  localparam logic signed [OUT_W-1:0] OUT_MAX = 17'sd65535;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -17'sd65536;

endpackage

// ===== sv/gno_octave.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gno_octave
// one octave lane: cell split, corner hash, gradient lookup, dots, blend, rescale
// ----------------------------------------------------------------------------
module gno_octave import gno_pkg::*; #(
  parameter int OCTAVE           = 0,
  parameter int ANGLE_TABLE_BITS = 8,
  parameter int FRAC_BITS        = 16
) (
  input  logic                        clk,
  input  logic signed [31:0]          x_coord,
  input  logic signed [31:0]          y_coord,
  output logic signed [CONTRIB_W-1:0] contrib
);

  localparam int FW    = FRAC_BITS;
  localparam int AB    = ANGLE_TABLE_BITS;
  localparam int RB    = AB - 2;
  localparam int NR    = 1 << RB;
  localparam int ENT_W = 2 * GRAD_W;
  localparam int TAB_W = ENT_W * NR;
  localparam int DOT_W = FW + GRAD_W + 2;
  localparam int PW    = FW + NOISE_W + 3;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  // quarter circle of {sin, cos} in q1.15 from truncated taylor series in q30
  function automatic logic [TAB_W-1:0] build_trig_table();
    logic [TAB_W-1:0] tab;
    longint phi, x2, t, s, c;
    tab = '0;
    for (int r = 0; r < NR; r++) begin
      phi = (longint'(r) * 64'sd1686629713) >>> RB;
      x2  = (phi * phi) >>> 30;
      t = (64'sd1 <<< 30) - ((x2 * (64'sd1 <<< 30)) >>> 30) / 110;
      t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 72;
      t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 42;
      t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 20;
      t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 6;
      s = (((phi * t) >>> 30) + 64'sd16384) >>> 15;
      t = (64'sd1 <<< 30) - ((x2 * (64'sd1 <<< 30)) >>> 30) / 132;
      t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 90;
      t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 56;
      t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 30;
      t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 12;
      t = (64'sd1 <<< 30) - ((x2 * t) >>> 30) / 2;
      c = (t + 64'sd16384) >>> 15;
      tab[r*ENT_W +: ENT_W] = {GRAD_W'(s), GRAD_W'(c)};
    end
    return tab;
  endfunction

  localparam logic [TAB_W-1:0] TRIG_TAB = build_trig_table();

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // stage 1: scale by two to the octave, split cell index and fraction
  logic signed [63:0] sx, sy;
  logic [31:0] s1_x0, s1_x1, s1_y0, s1_y1;
  logic [FW-1:0] s1_tx, s1_ty;

  assign sx = 64'(x_coord) <<< OCTAVE;
  assign sy = 64'(y_coord) <<< OCTAVE;

  always_ff @(posedge clk) begin
    s1_x0 <= sx[FW+31:FW];
    s1_x1 <= sx[FW+31:FW] + 32'd1;
    s1_y0 <= sy[FW+31:FW];
    s1_y1 <= sy[FW+31:FW] + 32'd1;
    s1_tx <= sx[FW-1:0];
    s1_ty <= sy[FW-1:0];
  end

  // stage 2: first hash multiply per column, fraction squares
  logic [31:0] s2_ax0, s2_ax1, s2_y0, s2_y1;
  logic [FW-1:0] s2_tx, s2_ty;
  logic [2*FW-1:0] s2_txsq, s2_tysq;

  always_ff @(posedge clk) begin
    s2_ax0  <= s1_x0 * HASH_K1;
    s2_ax1  <= s1_x1 * HASH_K1;
    s2_y0   <= s1_y0;
    s2_y1   <= s1_y1;
    s2_tx   <= s1_tx;
    s2_ty   <= s1_ty;
    s2_txsq <= s1_tx * s1_tx;
    s2_tysq <= s1_ty * s1_ty;
  end

  // stage 3: second hash multiply per corner (order 00, 10, 01, 11), smoothstep products
  logic [31:0] s3_a [4];
  logic [31:0] s3_b [4];
  logic [FW-1:0] s3_tx, s3_ty;
  logic [2*FW+1:0] s3_wxp, s3_wyp;
  logic [FW+1:0] three_x, three_y;

  assign three_x = (FW+2)'(3) << FW;
  assign three_y = (FW+2)'(3) << FW;

  always_ff @(posedge clk) begin
    s3_a[0] <= s2_ax0;
    s3_a[1] <= s2_ax1;
    s3_a[2] <= s2_ax0;
    s3_a[3] <= s2_ax1;
    s3_b[0] <= (s2_y0 ^ rot16(s2_ax0)) * HASH_K2;
    s3_b[1] <= (s2_y0 ^ rot16(s2_ax1)) * HASH_K2;
    s3_b[2] <= (s2_y1 ^ rot16(s2_ax0)) * HASH_K2;
    s3_b[3] <= (s2_y1 ^ rot16(s2_ax1)) * HASH_K2;
    s3_tx   <= s2_tx;
    s3_ty   <= s2_ty;
    s3_wxp  <= s2_txsq[2*FW-1:FW] * (three_x - {1'b0, s2_tx, 1'b0});
    s3_wyp  <= s2_tysq[2*FW-1:FW] * (three_y - {1'b0, s2_ty, 1'b0});
  end

  // stage 4: final hash multiply, smoothstep weights
  logic [31:0] s4_h [4];
  logic [FW-1:0] s4_tx, s4_ty;
  logic [FW:0] s4_wx, s4_wy;

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      s4_h[c] <= (s3_a[c] ^ rot16(s3_b[c])) * HASH_K3;
    end
    s4_tx <= s3_tx;
    s4_ty <= s3_ty;
    s4_wx <= s3_wxp[2*FW:FW];
    s4_wy <= s3_wyp[2*FW:FW];
  end

  // stage 5: gradient from the top hash bits
  logic signed [GRAD_W-1:0] gx_w [4];
  logic signed [GRAD_W-1:0] gy_w [4];
  logic signed [GRAD_W-1:0] s5_gx [4];
  logic signed [GRAD_W-1:0] s5_gy [4];
  logic [FW-1:0] s5_tx, s5_ty;
  logic [FW:0] s5_wx, s5_wy;

  always_comb begin
    logic [AB-1:0] k;
    logic [ENT_W-1:0] ent;
    logic signed [GRAD_W-1:0] cv, sv;
    for (int c = 0; c < 4; c++) begin
      k   = s4_h[c][31 -: AB];
      ent = TRIG_TAB[k[RB-1:0]*ENT_W +: ENT_W];
      cv  = signed'(ent[GRAD_W-1:0]);
      sv  = signed'(ent[ENT_W-1:GRAD_W]);
      case (k[AB-1 -: 2])
        QUAD_0: begin gx_w[c] = cv;  gy_w[c] = sv;  end
        QUAD_1: begin gx_w[c] = -sv; gy_w[c] = cv;  end
        QUAD_2: begin gx_w[c] = -cv; gy_w[c] = -sv; end
        default: begin gx_w[c] = sv; gy_w[c] = -cv; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s5_gx <= gx_w;
    s5_gy <= gy_w;
    s5_tx <= s4_tx;
    s5_ty <= s4_ty;
    s5_wx <= s4_wx;
    s5_wy <= s4_wy;
  end

  // stage 6: corner dot products; the far corner offset is t - 1
  logic signed [FW:0] dx_w [2];
  logic signed [FW:0] dy_w [2];
  logic signed [NOISE_W-1:0] s6_n [4];
  logic [FW:0] s6_wx, s6_wy;

  assign dx_w[0] = signed'({1'b0, s5_tx});
  assign dx_w[1] = signed'({1'b1, s5_tx});
  assign dy_w[0] = signed'({1'b0, s5_ty});
  assign dy_w[1] = signed'({1'b1, s5_ty});

  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      s6_n[c] <= NOISE_W'((DOT_W'(dx_w[c%2] * s5_gx[c]) + DOT_W'(dy_w[c/2] * s5_gy[c]))
                 >>> FW);
    end
    s6_wx <= s5_wx;
    s6_wy <= s5_wy;
  end

  // stage 7: x blend products
  logic signed [PW-1:0] s7_plo, s7_phi;
  logic signed [NOISE_W-1:0] s7_n00, s7_n01;
  logic [FW:0] s7_wy;

  always_ff @(posedge clk) begin
    s7_plo <= PW'(signed'({1'b0, s6_wx}) * ((NOISE_W+1)'(s6_n[1]) - (NOISE_W+1)'(s6_n[0])));
    s7_phi <= PW'(signed'({1'b0, s6_wx}) * ((NOISE_W+1)'(s6_n[3]) - (NOISE_W+1)'(s6_n[2])));
    s7_n00 <= s6_n[0];
    s7_n01 <= s6_n[2];
    s7_wy  <= s6_wy;
  end

  // stage 8: x blend sums
  logic signed [NOISE_W-1:0] s8_lo, s8_hi;
  logic [FW:0] s8_wy;

  always_ff @(posedge clk) begin
    s8_lo <= s7_n00 + NOISE_W'(s7_plo >>> FW);
    s8_hi <= s7_n01 + NOISE_W'(s7_phi >>> FW);
    s8_wy <= s7_wy;
  end

  // stage 9: y blend product
  logic signed [PW-1:0] s9_pv;
  logic signed [NOISE_W-1:0] s9_lo;

  always_ff @(posedge clk) begin
    s9_pv <= PW'(signed'({1'b0, s8_wy}) * ((NOISE_W+1)'(s8_hi) - (NOISE_W+1)'(s8_lo)));
    s9_lo <= s8_lo;
  end

  // stage 10: y blend sum, clamp to 0.7, split sign and magnitude
  logic signed [NOISE_W-1:0] v_w;
  logic [MAG_W-1:0] s10_mag;
  logic s10_neg;

  assign v_w = s9_lo + NOISE_W'(s9_pv >>> FW);

  always_ff @(posedge clk) begin
    s10_neg <= v_w[NOISE_W-1];
    if (v_w > NOISE_W'(CLAMP_Q15) || v_w < -NOISE_W'(CLAMP_Q15)) begin
      s10_mag <= MAG_W'(CLAMP_Q15);
    end else if (v_w[NOISE_W-1]) begin
      s10_mag <= MAG_W'(-v_w);
    end else begin
      s10_mag <= MAG_W'(v_w);
    end
  end

  // stage 11: quotient estimate by reciprocal
  logic [MAG_W+RECIP_W-1:0] s11_qp;
  logic [MAG_W-1:0] s11_mag;
  logic s11_neg;

  always_ff @(posedge clk) begin
    s11_qp  <= s10_mag * RECIP_CLAMP;
    s11_mag <= s10_mag;
    s11_neg <= s10_neg;
  end

  // stage 12: remainder of the estimate
  logic [15:0] qest_w;
  logic [15:0] s12_q;
  logic [31:0] s12_rem;
  logic s12_neg;

  assign qest_w = s11_qp[RECIP_SHIFT +: 16];

  always_ff @(posedge clk) begin
    s12_rem <= {2'b00, s11_mag, 15'd0} - qest_w * 32'(CLAMP_Q15);
    s12_q   <= qest_w;
    s12_neg <= s11_neg;
  end

  // stage 13: correct by one, scale down by the octave, restore sign
  logic [16:0] q_w;

  assign q_w = ({1'b0, s12_q} + ((s12_rem >= 32'(CLAMP_Q15)) ? 17'd1 : 17'd0)) >> OCTAVE;

  always_ff @(posedge clk) begin
    contrib <= s12_neg ? -signed'(q_w) : signed'(q_w);
  end

endmodule

// ===== sv/gradient_noise_2d_octaves.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_octaves
// fractal sum of 2d gradient noise over up to MAX_OCTAVES octaves
// ----------------------------------------------------------------------------
// Takes one sample point per cycle and returns one noise value per point. A
// point is taken at every clock edge where start is high and busy is low; busy
// is low whenever the block is out of reset. Each point passes the input
// register, its octave lanes, the sum register and the saturation register,
// then noise_valid stays high for exactly one cycle beside the noise value.
// Results come out in the order the points came in. There is no way to hold a
// result back, so the receiver must take it in that cycle. Every octave has
// its own 13-stage lane (hash multiplies, gradient lookup, dot products, blend
// and rescale), all lanes run side by side, then one stage sums the lanes and
// one saturates. octave_count is written over the cfg port and should only
// change while no point is in flight.
// ----------------------------------------------------------------------------
module gradient_noise_2d_octaves import gno_pkg::*; #(
  parameter int MAX_OCTAVES      = 8,
  parameter int ANGLE_TABLE_BITS = 8,
  parameter int FRAC_BITS        = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [31:0]      x_coord,
  input  logic signed [31:0]      y_coord,
  output logic                    noise_valid,
  output logic signed [OUT_W-1:0] noise_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_data
);

  // nothing stalls inside, so points are refused only while in reset
  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // octave count register
  logic [CFG_W-1:0] octave_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      octave_count <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      octave_count <= cfg_data;
    end
  end

  // input register and the valid bit that walks beside the lanes
  logic signed [31:0] in_x, in_y;
  logic [LANE_LAT:0] vld;

  always_ff @(posedge clk) begin
    in_x <= x_coord;
    in_y <= y_coord;
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LANE_LAT-1:0], start && !busy};
    end
  end

  // one lane per octave
  logic signed [CONTRIB_W-1:0] contrib [MAX_OCTAVES];

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_octave
    gno_octave #(
      .OCTAVE           (i),
      .ANGLE_TABLE_BITS (ANGLE_TABLE_BITS),
      .FRAC_BITS        (FRAC_BITS)
    ) u_octave (
      .clk     (clk),
      .x_coord (in_x),
      .y_coord (in_y),
      .contrib (contrib[i])
    );
  end

  // sum of the enabled octaves; counts above MAX_OCTAVES enable every lane
  logic signed [SUM_W-1:0] sum_w, sum_q;
  logic sum_vld;

  always_comb begin
    sum_w = '0;
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (CFG_W'(i) < octave_count) begin
        sum_w = sum_w + SUM_W'(contrib[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    sum_q <= sum_w;
    if (rst) begin
      sum_vld <= 1'b0;
    end else begin
      sum_vld <= vld[LANE_LAT];
    end
  end

  // saturate to the q1.15 output range
  always_ff @(posedge clk) begin
    if (sum_q > SUM_W'(OUT_MAX)) begin
      noise_value <= OUT_MAX;
    end else if (sum_q < SUM_W'(OUT_MIN)) begin
      noise_value <= OUT_MIN;
    end else begin
      noise_value <= OUT_W'(sum_q);
    end
    if (rst) begin
      noise_valid <= 1'b0;
    end else begin
      noise_valid <= sum_vld;
    end
  end

endmodule

// ===== sv/gno_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gno_checker
// port-level checks of the noise pipeline, bound to the top level
// ----------------------------------------------------------------------------
module gno_checker import gno_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic noise_valid,
  input logic cfg_ready
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  // cycles out of reset, saturating at the pipeline depth
  logic [CNT_W-1:0] since_rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != CNT_W'(PIPE_DEPTH)) begin
      since_rst <= since_rst + CNT_W'(1);
    end
  end

  // every item comes out exactly once, after passing the whole pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (since_rst == CNT_W'(PIPE_DEPTH)) |-> (noise_valid == $past(start && !busy, PIPE_DEPTH)))
    else $error("result strobe does not match item taken earlier");

  a_flush: assert property (@(posedge clk) rst |=> !noise_valid)
    else $error("result strobe after reset");

  a_open: assert property (@(posedge clk) !rst |-> (cfg_ready && !busy))
    else $error("block refused an item or a register write out of reset");

endmodule

bind gradient_noise_2d_octaves gno_checker u_gno_checker (.*);
